// File: sv/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg: shared types and constants of the 3x3 box blur
// Word layouts, field widths, register indexes and setup states.
// ----------------------------------------------------------------------------
package bb3_pkg;

   // Field widths
   localparam int CHAN_BITS      = 8;
   localparam int PIX_BITS       = 3 * CHAN_BITS;
   localparam int WIDTH_BITS     = 11;
   localparam int HEIGHT_BITS    = 13;
   localparam int COUNT_BITS     = 23;
   localparam int ROW_BITS       = 12;
   localparam int CSR_DATA_BITS  = 13;
   localparam int CSR_INDEX_BITS = 2;

   // Defaults and limits
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int WIDTH_RESET    = 640;
   localparam int HEIGHT_RESET   = 480;
   localparam int HEIGHT_CAP     = 4096;
   localparam int NUM_LANES      = 3;
   localparam int WIN_CELLS      = 9;
   localparam int OUTQ_DEPTH     = 8;
   localparam int OUTQ_LVL_BITS  = $clog2(OUTQ_DEPTH + 1);

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

   // Lane order inside the merged word
   localparam int LANE_RED   = 0;
   localparam int LANE_GREEN = 1;
   localparam int LANE_BLUE  = 2;

   typedef struct packed {
      logic [CHAN_BITS-1:0] pix_red;
      logic [CHAN_BITS-1:0] pix_green;
      logic [CHAN_BITS-1:0] pix_blue;
   } req_word_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0] out_red;
      logic [CHAN_BITS-1:0] out_green;
      logic [CHAN_BITS-1:0] out_blue;
      logic                 frame_end;
   } rsp_word_type;

   // Which neighbors of the output pixel lie inside the frame
   typedef struct packed {
      logic left;
      logic right;
      logic top;
      logic bottom;
   } nbr_type;

   typedef enum logic [2:0] {
      SEQ_LIMITS,
      SEQ_AREA,
      SEQ_LAST,
      SEQ_CLAMP,
      SEQ_DIVIDE,
      SEQ_RUN
   } seq_state_type;

endpackage

// File: sv/bb3_lines.sv
// ----------------------------------------------------------------------------
// bb3_lines: line store and 3x3 window
// One wide store keeps the upper and middle rows per column; the window
// shifts in one column per pixel word.
// ----------------------------------------------------------------------------
module bb3_lines #(
   parameter int MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH,
   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [AW-1:0]                col,
   input  logic [bb3_pkg::PIX_BITS-1:0] cur,
   output logic [bb3_pkg::PIX_BITS-1:0] window [9]
);
   import bb3_pkg::*;

   localparam int LW = 2 * PIX_BITS;

   logic [LW-1:0]       store [MAX_WIDTH];
   logic [LW-1:0]       rd_ff;
   logic                s1_v_ff;
   logic [AW-1:0]       s1_col_ff;
   logic [PIX_BITS-1:0] s1_cur_ff;
   logic                byp_ff;
   logic                byp_in;
   logic [LW-1:0]       byp_data_ff;
   logic [LW-1:0]       line_word;
   logic [LW-1:0]       wr_word;
   logic [PIX_BITS-1:0] up;
   logic [PIX_BITS-1:0] mid;
   logic [PIX_BITS-1:0] win_ff [9];

   // Pick the stored column, or the write that lands in the same cycle
   always_comb begin
      line_word = byp_ff ? byp_data_ff : rd_ff;
      up        = line_word[LW-1:PIX_BITS];
      mid       = line_word[PIX_BITS-1:0];
      wr_word   = {mid, s1_cur_ff};
      byp_in    = s1_v_ff && (s1_col_ff == col);
   end

   // Read on accept, write back in the following cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= store[col];
      end
      if (s1_v_ff) begin
         store[s1_col_ff] <= wr_word;
      end
   end

   // Hold the word in flight and the forward flag
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= accept;
      end
      if (accept) begin
         s1_col_ff   <= col;
         s1_cur_ff   <= cur;
         byp_ff      <= byp_in;
         byp_data_ff <= wr_word;
      end
   end

   // Advance the window by one column
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < WIN_CELLS; n++) begin
            win_ff[n] <= '0;
         end
      end else if (s1_v_ff) begin
         for (int n = 0; n < 6; n++) begin
            win_ff[n] <= win_ff[n + 3];
         end
         win_ff[6] <= up;
         win_ff[7] <= mid;
         win_ff[8] <= s1_cur_ff;
      end
   end

   assign window = win_ff;

endmodule

// File: sv/bb3_lane.sv
// ----------------------------------------------------------------------------
// bb3_lane: one color channel of the blur
// Masked sum of the window, then a reciprocal multiply for the mean.
// ----------------------------------------------------------------------------
module bb3_lane (
   input  logic                          clock,
   input  logic [bb3_pkg::CHAN_BITS-1:0] cells [9],
   input  bb3_pkg::nbr_type              nbr,
   output logic [bb3_pkg::CHAN_BITS-1:0] mean
);
   import bb3_pkg::*;

   localparam int SUM_BITS  = CHAN_BITS + 4;
   localparam int SHIFT     = CHAN_BITS + 7;
   localparam int RW        = SHIFT + 1;
   localparam int PROD_BITS = SUM_BITS + RW;

   localparam logic [RW-1:0] RECIP_1 = RW'(1 << SHIFT);
   localparam logic [RW-1:0] RECIP_2 = RW'(((1 << SHIFT) + 1) / 2);
   localparam logic [RW-1:0] RECIP_3 = RW'(((1 << SHIFT) + 2) / 3);
   localparam logic [RW-1:0] RECIP_4 = RW'(((1 << SHIFT) + 3) / 4);
   localparam logic [RW-1:0] RECIP_6 = RW'(((1 << SHIFT) + 5) / 6);
   localparam logic [RW-1:0] RECIP_9 = RW'(((1 << SHIFT) + 8) / 9);

   logic [WIN_CELLS-1:0] use_cell;
   logic [SUM_BITS-1:0]  sum_in;
   logic [SUM_BITS-1:0]  sum_ff;
   logic [1:0]           ncols;
   logic [1:0]           nrows;
   logic [3:0]           cnt_in;
   logic [3:0]           cnt_ff;
   logic [RW-1:0]        recip;
   logic [PROD_BITS-1:0] prod_ff;

   // Keep only the neighbors inside the frame
   always_comb begin
      for (int col = 0; col < 3; col++) begin
         for (int row = 0; row < 3; row++) begin
            use_cell[col * 3 + row] = !((col == 0) && !nbr.left)
                                   && !((col == 2) && !nbr.right)
                                   && !((row == 0) && !nbr.top)
                                   && !((row == 2) && !nbr.bottom);
         end
      end
      sum_in = '0;
      for (int n = 0; n < WIN_CELLS; n++) begin
         if (use_cell[n]) begin
            sum_in = sum_in + SUM_BITS'(cells[n]);
         end
      end
      ncols  = 2'd1 + 2'(nbr.left) + 2'(nbr.right);
      nrows  = 2'd1 + 2'(nbr.top) + 2'(nbr.bottom);
      cnt_in = 4'(ncols) * 4'(nrows);
   end

   // Reciprocal of the neighbor count, rounded up
   always_comb begin
      case (cnt_ff)
         4'd1:    recip = RECIP_1;
         4'd2:    recip = RECIP_2;
         4'd3:    recip = RECIP_3;
         4'd4:    recip = RECIP_4;
         4'd6:    recip = RECIP_6;
         default: recip = RECIP_9;
      endcase
   end

   // Sum stage, then product stage
   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      cnt_ff  <= cnt_in;
      prod_ff <= PROD_BITS'(sum_ff) * PROD_BITS'(recip);
   end

   assign mean = prod_ff[SHIFT +: CHAN_BITS];

endmodule

// File: sv/bb3_divider.sv
// ----------------------------------------------------------------------------
// bb3_divider: restoring divider for counter setup
// One quotient bit per cycle; pulses done when quotient and remainder hold.
// ----------------------------------------------------------------------------
module bb3_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [bb3_pkg::COUNT_BITS-1:0] dividend,
   input  logic [bb3_pkg::WIDTH_BITS-1:0] divisor,
   output logic                           done,
   output logic [bb3_pkg::COUNT_BITS-1:0] quotient,
   output logic [bb3_pkg::WIDTH_BITS-1:0] remainder
);
   import bb3_pkg::*;

   localparam int STEP_BITS = $clog2(COUNT_BITS + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic [COUNT_BITS-1:0] quo_ff;
   logic [WIDTH_BITS-1:0] rem_ff;
   logic [WIDTH_BITS:0]   trial;
   logic                  fits;
   logic [WIDTH_BITS:0]   diff;

   // Shift in the next dividend bit and try to subtract
   always_comb begin
      trial = {rem_ff, quo_ff[COUNT_BITS-1]};
      fits  = trial >= {1'b0, divisor};
      diff  = trial - {1'b0, divisor};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_BITS'(COUNT_BITS);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[COUNT_BITS-2:0], fits};
         rem_ff <= fits ? diff[WIDTH_BITS-1:0] : trial[WIDTH_BITS-1:0];
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: sv/bb3_merge_q.sv
// ----------------------------------------------------------------------------
// bb3_merge_q: lane merge and result queue
// Packs the three lane means with the frame flag and queues result words.
// ----------------------------------------------------------------------------
module bb3_merge_q (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  logic [bb3_pkg::CHAN_BITS-1:0]     lane_mean [3],
   input  logic                              frame_end,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bb3_pkg::rsp_word_type             rsp_data,
   output logic [bb3_pkg::OUTQ_LVL_BITS-1:0] level
);
   import bb3_pkg::*;

   localparam int PTR_BITS = $clog2(OUTQ_DEPTH);

   rsp_word_type              slot_ff [OUTQ_DEPTH];
   rsp_word_type              merged;
   logic [PTR_BITS-1:0]       wr_ptr_ff;
   logic [PTR_BITS-1:0]       rd_ptr_ff;
   logic [OUTQ_LVL_BITS-1:0]  level_ff;
   logic                      pop;

   // Combine the lanes into one result word
   always_comb begin
      merged.out_red   = lane_mean[LANE_RED];
      merged.out_green = lane_mean[LANE_GREEN];
      merged.out_blue  = lane_mean[LANE_BLUE];
      merged.frame_end = frame_end;
      pop              = rsp_valid && rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= merged;
      end
   end

   // Advance pointers and track the fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   level_ff <= level_ff + 1'b1;
            2'b01:   level_ff <= level_ff - 1'b1;
            default: level_ff <= level_ff;
         endcase
      end
   end

   assign rsp_valid = level_ff != '0;
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign level     = level_ff;

endmodule

// File: sv/box_blur_3x3_border_mean.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_border_mean: 3x3 mean filter over an RGB raster stream
// A result word passes the line store, the window, the lane sum and product
//   registers and the result queue; it belongs to the pixel width+1 words behind.
// Throughput: one word per cycle while setup is done and the queue has room.
// Reset and register writes start a setup pass (limits, frame area, last word,
//   clamp, and a 23-step column divide mid-frame) with req_ready low; csr_ready stays high.
// ----------------------------------------------------------------------------
module box_blur_3x3_border_mean #(
   parameter int MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  bb3_pkg::req_word_type              req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output bb3_pkg::rsp_word_type              rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bb3_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bb3_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import bb3_pkg::*;

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WIDTH_MAX_REG = (1 << WIDTH_BITS) - 1;
   localparam logic [WIDTH_BITS-1:0] W_CAP =
      WIDTH_BITS'((MAX_WIDTH > WIDTH_MAX_REG) ? WIDTH_MAX_REG : MAX_WIDTH);
   localparam logic [HEIGHT_BITS-1:0] H_CAP = HEIGHT_BITS'(HEIGHT_CAP);

   seq_state_type           seq_ff;
   seq_state_type           seq_in;
   logic [WIDTH_BITS-1:0]   fw_ff;
   logic [HEIGHT_BITS-1:0]  fh_ff;
   logic [WIDTH_BITS-1:0]   eff_w_ff;
   logic [HEIGHT_BITS-1:0]  eff_h_ff;
   logic [COUNT_BITS-1:0]   pixels_ff;
   logic [COUNT_BITS-1:0]   last_ff;
   logic [COUNT_BITS-1:0]   k_ff;
   logic [COUNT_BITS-1:0]   k_in;
   logic [AW-1:0]           c_ff;
   logic [AW-1:0]           c_in;
   logic [ROW_BITS-1:0]     i_ff;
   logic [ROW_BITS-1:0]     i_in;

   logic                    csr_wr;
   logic                    acc;
   logic                    running;
   logic                    need_div;
   logic                    div_start;
   logic                    div_done;
   logic [COUNT_BITS-1:0]   div_quo;
   logic [WIDTH_BITS-1:0]   div_rem;

   logic [COUNT_BITS-1:0]   w_ext;
   logic [WIDTH_BITS-1:0]   w_m1;
   logic [WIDTH_BITS-1:0]   c_wide;
   logic [WIDTH_BITS-1:0]   j_wide;
   logic                    has_result;
   logic                    last_hit;
   nbr_type                 nbr_in;
   logic [PIX_BITS-1:0]     cur;

   logic                    r1_ff, r2_ff, r3_ff, r4_ff;
   logic                    fe1_ff, fe2_ff, fe3_ff, fe4_ff;
   nbr_type                 nbr1_ff;
   nbr_type                 nbr2_ff;
   logic [OUTQ_LVL_BITS-1:0] q_level;
   logic [OUTQ_LVL_BITS:0]  inflight;

   logic [PIX_BITS-1:0]     window [9];
   logic [CHAN_BITS-1:0]    cells [NUM_LANES][9];
   logic [CHAN_BITS-1:0]    lane_mean [3];

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign acc       = req_valid && req_ready;
   assign need_div  = (k_ff <= last_ff) && (k_ff != '0);

   // Setup sequencer: next state
   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         SEQ_LIMITS: seq_in = SEQ_AREA;
         SEQ_AREA:   seq_in = SEQ_LAST;
         SEQ_LAST:   seq_in = SEQ_CLAMP;
         SEQ_CLAMP:  seq_in = need_div ? SEQ_DIVIDE : SEQ_RUN;
         SEQ_DIVIDE: seq_in = div_done ? SEQ_RUN : SEQ_DIVIDE;
         SEQ_RUN:    seq_in = SEQ_RUN;
         default:    seq_in = SEQ_LIMITS;
      endcase
      if (csr_wr) begin
         seq_in = SEQ_LIMITS;
      end
   end

   // Setup sequencer: outputs
   always_comb begin
      running   = seq_ff == SEQ_RUN;
      div_start = (seq_ff == SEQ_CLAMP) && need_div && !csr_wr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= SEQ_LIMITS;
      end else begin
         seq_ff <= seq_in;
      end
   end

   // Rebuild the column and row from the word count after a register change
   bb3_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (k_ff - 1'b1),
      .divisor   (eff_w_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Position of the word and its output pixel
   always_comb begin
      w_ext      = COUNT_BITS'(eff_w_ff);
      w_m1       = eff_w_ff - 1'b1;
      c_wide     = WIDTH_BITS'(c_ff);
      j_wide     = (c_wide == '0) ? w_m1 : c_wide - 1'b1;
      has_result = k_ff > w_ext;
      last_hit   = k_ff == last_ff;
      cur        = (k_ff < pixels_ff) ? PIX_BITS'(req_data) : '0;

      nbr_in.left   = j_wide != '0;
      nbr_in.right  = j_wide != w_m1;
      nbr_in.top    = i_ff != '0;
      nbr_in.bottom = ({1'b0, i_ff} + 1'b1) < eff_h_ff;

      k_in = last_hit ? '0 : k_ff + 1'b1;
      if (last_hit || (c_wide == w_m1)) begin
         c_in = '0;
      end else begin
         c_in = AW'(c_wide + 1'b1);
      end
      if (last_hit || (k_ff <= w_ext)) begin
         i_in = '0;
      end else begin
         i_in = i_ff + ROW_BITS'(c_wide == '0);
      end
   end

   // Registers, frame limits and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff     <= WIDTH_BITS'(WIDTH_RESET);
         fh_ff     <= HEIGHT_BITS'(HEIGHT_RESET);
         eff_w_ff  <= WIDTH_BITS'(1);
         eff_h_ff  <= HEIGHT_BITS'(1);
         pixels_ff <= '0;
         last_ff   <= '0;
         k_ff      <= '0;
         c_ff      <= '0;
         i_ff      <= '0;
      end else begin
         if (csr_wr && (csr_index == REG_FRAME_WIDTH)) begin
            fw_ff <= csr_data[WIDTH_BITS-1:0];
         end
         if (csr_wr && (csr_index == REG_FRAME_HEIGHT)) begin
            fh_ff <= csr_data[HEIGHT_BITS-1:0];
         end
         case (seq_ff)
            SEQ_LIMITS: begin
               if (fw_ff == '0) begin
                  eff_w_ff <= WIDTH_BITS'(1);
               end else if (fw_ff > W_CAP) begin
                  eff_w_ff <= W_CAP;
               end else begin
                  eff_w_ff <= fw_ff;
               end
               if (fh_ff == '0) begin
                  eff_h_ff <= HEIGHT_BITS'(1);
               end else if (fh_ff > H_CAP) begin
                  eff_h_ff <= H_CAP;
               end else begin
                  eff_h_ff <= fh_ff;
               end
            end
            SEQ_AREA: begin
               pixels_ff <= COUNT_BITS'(eff_w_ff * eff_h_ff);
            end
            SEQ_LAST: begin
               last_ff <= pixels_ff + w_ext;
            end
            SEQ_CLAMP: begin
               if (!need_div) begin
                  k_ff <= (k_ff > last_ff) ? '0 : k_ff;
                  c_ff <= '0;
                  i_ff <= '0;
               end
            end
            SEQ_DIVIDE: begin
               if (div_done) begin
                  c_ff <= (div_rem == w_m1) ? '0 : AW'(div_rem + 1'b1);
                  i_ff <= (div_quo == '0) ? '0 : ROW_BITS'(div_quo - 1'b1);
               end
            end
            SEQ_RUN: begin
               if (acc) begin
                  k_ff <= k_in;
                  c_ff <= c_in;
                  i_ff <= i_in;
               end
            end
            default: begin
               k_ff <= k_ff;
            end
         endcase
      end
   end

   // Admit a word only while running and the queue has room for everything in flight
   always_comb begin
      inflight  = {1'b0, q_level} + (OUTQ_LVL_BITS + 1)'(r1_ff)
                + (OUTQ_LVL_BITS + 1)'(r2_ff) + (OUTQ_LVL_BITS + 1)'(r3_ff)
                + (OUTQ_LVL_BITS + 1)'(r4_ff);
      req_ready = running && (inflight < (OUTQ_LVL_BITS + 1)'(OUTQ_DEPTH));
   end

   bb3_lines #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_lines (
      .clock  (clock),
      .reset  (reset),
      .accept (acc),
      .col    (c_ff),
      .cur    (cur),
      .window (window)
   );

   // Result tracking along the lane pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         r1_ff <= 1'b0;
         r2_ff <= 1'b0;
         r3_ff <= 1'b0;
         r4_ff <= 1'b0;
      end else begin
         r1_ff <= acc && has_result;
         r2_ff <= r1_ff;
         r3_ff <= r2_ff;
         r4_ff <= r3_ff;
      end
      fe1_ff  <= last_hit;
      fe2_ff  <= fe1_ff;
      fe3_ff  <= fe2_ff;
      fe4_ff  <= fe3_ff;
      nbr1_ff <= nbr_in;
      nbr2_ff <= nbr1_ff;
   end

   // Split the window into channels, one lane each
   always_comb begin
      for (int ch = 0; ch < NUM_LANES; ch++) begin
         for (int n = 0; n < WIN_CELLS; n++) begin
            cells[ch][n] = window[n][PIX_BITS - 1 - ch * CHAN_BITS -: CHAN_BITS];
         end
      end
   end

   for (genvar ch = 0; ch < NUM_LANES; ch++) begin : g_lane
      bb3_lane u_lane (
         .clock (clock),
         .cells (cells[ch]),
         .nbr   (nbr2_ff),
         .mean  (lane_mean[ch])
      );
   end

   bb3_merge_q u_merge_q (
      .clock     (clock),
      .reset     (reset),
      .push      (r4_ff),
      .lane_mean (lane_mean),
      .frame_end (fe4_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .level     (q_level)
   );

   // The queue never takes a word while full
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      r4_ff |-> (q_level < OUTQ_LVL_BITS'(OUTQ_DEPTH)))
      else $error("result queue overflow");

   // The column counter stays inside the frame while streaming
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      running |-> (WIDTH_BITS'(c_ff) < eff_w_ff))
      else $error("column counter out of range");

   // The last word of a frame restarts the count
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (acc && last_hit) |=> ((k_ff == '0) && (c_ff == '0)))
      else $error("frame did not restart");

endmodule
